// File: hw/rtl/tdc_pkg.sv
// ----------------------------------------------------------------------------
// tdc_pkg
// Shared types and codes for the transmit ring DMA chunker.
// ----------------------------------------------------------------------------
package tdc_pkg;

    // request codes carried on req_type
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_DONE  = 1'b1;

    localparam int OUT_W = 8;   // width of dma_addr / dma_len

    typedef struct packed {
        logic             accepted;
        logic             dma_start;
        logic [OUT_W-1:0] dma_addr;
        logic [OUT_W-1:0] dma_len;
        logic             dma_enable;
    } result_t;

endpackage

// File: hw/rtl/tdc_ring_mem.sv
// ----------------------------------------------------------------------------
// tdc_ring_mem
// Byte storage of the transmit ring, one write port indexed by the head.
// ----------------------------------------------------------------------------
module tdc_ring_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);

    logic [7:0] ring_mem [DEPTH];

    // contents are drained by the DMA engine through its own path
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
    end

endmodule

// File: hw/rtl/tdc_ctrl.sv
// ----------------------------------------------------------------------------
// tdc_ctrl
// Head/tail bookkeeping, chunk issue and DMA enable for one transfer per cycle in which step is high.
// ----------------------------------------------------------------------------
module tdc_ctrl #(
    parameter int RING_SIZE = 256,
    parameter int IW        = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              req_type,
    input  logic [7:0]        data_byte,
    input  logic              last_in_write,
    output tdc_pkg::result_t  res,
    output logic              wr_en,
    output logic [IW-1:0]     wr_addr,
    output logic [7:0]        wr_data
);

    localparam logic [IW:0]   SIZE_W = (IW+1)'(RING_SIZE);
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_SIZE - 1);

    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [IW-1:0] issued_reg, issued_next;
    logic          in_flight_reg, in_flight_next;
    logic          enable_reg, enable_next;
    logic          cwa_reg, cwa_next;

    logic [IW-1:0] head_inc;
    logic          full;
    logic [IW:0]   tail_sum;
    logic [IW-1:0] tail_done;
    logic [IW-1:0] h, t;
    logic          try_en, busy_pre;
    logic          issue;
    logic [IW:0]   run;
    logic [31:0]   addr_ext, len_ext;

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign full     = (head_inc == tail_reg);

    // issued length never carries the tail more than one wrap
    assign tail_sum  = {1'b0, tail_reg} + {1'b0, issued_reg};
    assign tail_done = (tail_sum >= SIZE_W) ? IW'(tail_sum - SIZE_W) : tail_sum[IW-1:0];

    always_comb
    begin
        cwa_next = cwa_reg;
        if (req_type == tdc_pkg::REQ_WRITE)
        begin
            h        = full ? head_reg : head_inc;
            t        = tail_reg;
            busy_pre = in_flight_reg;
            try_en   = last_in_write && (cwa_reg || !full);
            if (!full)
                cwa_next = 1'b1;
            if (last_in_write)
                cwa_next = 1'b0;
        end
        else
        begin
            h        = head_reg;
            t        = tail_done;
            busy_pre = 1'b0;
            try_en   = 1'b1;
        end
    end

    // largest contiguous run from the tail that does not wrap
    assign issue = try_en && !busy_pre && (h != t);
    assign run   = (h >= t) ? ({1'b0, h} - {1'b0, t}) : (SIZE_W - {1'b0, t});

    always_comb
    begin
        head_next      = h;
        tail_next      = t;
        in_flight_next = busy_pre;
        issued_next    = (req_type == tdc_pkg::REQ_WRITE) ? issued_reg : '0;
        enable_next    = enable_reg;
        if (issue)
        begin
            issued_next    = run[IW-1:0];
            in_flight_next = 1'b1;
            enable_next    = 1'b1;
        end
        else if (req_type == tdc_pkg::REQ_DONE && h == t)
        begin
            enable_next = 1'b0;
        end
    end

    assign addr_ext = 32'(t);
    assign len_ext  = 32'(run[IW-1:0]);

    always_comb
    begin
        res.accepted   = (req_type == tdc_pkg::REQ_WRITE) && !full;
        res.dma_start  = issue;
        res.dma_addr   = issue ? addr_ext[tdc_pkg::OUT_W-1:0] : '0;
        res.dma_len    = issue ? len_ext[tdc_pkg::OUT_W-1:0] : '0;
        res.dma_enable = enable_next;
    end

    assign wr_en   = step && (req_type == tdc_pkg::REQ_WRITE) && !full;
    assign wr_addr = head_reg;
    assign wr_data = data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            issued_reg    <= '0;
            in_flight_reg <= 1'b0;
            enable_reg    <= 1'b0;
            cwa_reg       <= 1'b0;
        end
        else if (step)
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            issued_reg    <= issued_next;
            in_flight_reg <= in_flight_next;
            enable_reg    <= enable_next;
            cwa_reg       <= cwa_next;
        end
    end

    a_busy_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg |-> enable_reg)
        else $error("transfer in flight with DMA enable low");

    a_len_tracks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg == (issued_reg != '0))
        else $error("issued length out of step with busy flag");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, head_reg} < SIZE_W) && ({1'b0, tail_reg} < SIZE_W))
        else $error("ring index beyond ring size");

    a_no_issue_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_flight_reg && req_type == tdc_pkg::REQ_WRITE) |-> !issue)
        else $error("second transfer issued while one is in flight");

    a_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (head_reg != $past(head_reg)))
        else $error("stored byte did not advance head");

endmodule

// File: hw/rtl/tx_ring_dma_chunker_core.sv
// ----------------------------------------------------------------------------
// tx_ring_dma_chunker_core
// Transmit ring buffer that hands contiguous chunks to a DMA engine.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): req_type selects a byte write (data_byte,
// last_in_write marks the end of a software write call) or a DMA completion.
// Output channel (out_valid/out_ready): one result per input transfer with
// accepted, the issue strobe dma_start with dma_addr/dma_len, and the DMA
// enable level after the step.
// The ring state updates and the result is registered at the edge that
// takes the input. One item per cycle is sustained while out_ready is high;
// the single output register is the only buffer.
// When the receiver stalls with a result pending, in_ready drops until that
// result is taken; in_ready is high again in the cycle out_ready is seen.
// Reset clears head, tail, busy, enable and the call tracking; the byte store
// has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module tx_ring_dma_chunker_core #(
    parameter int RING_SIZE = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    input  logic       last_in_write,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       accepted,
    output logic       dma_start,
    output logic [7:0] dma_addr,
    output logic [7:0] dma_len,
    output logic       dma_enable
);

    localparam int IW = (RING_SIZE > 2) ? $clog2(RING_SIZE) : 1;

    logic              step;
    tdc_pkg::result_t  res;
    tdc_pkg::result_t  res_reg;
    logic              out_valid_reg, out_valid_next;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [7:0]        wr_data;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    tdc_ctrl #(
        .RING_SIZE (RING_SIZE),
        .IW        (IW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .req_type      (req_type),
        .data_byte     (data_byte),
        .last_in_write (last_in_write),
        .res           (res),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    tdc_ring_mem #(
        .DEPTH (RING_SIZE),
        .AW    (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign out_valid_next = step || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign accepted   = res_reg.accepted;
    assign dma_start  = res_reg.dma_start;
    assign dma_addr   = res_reg.dma_addr;
    assign dma_len    = res_reg.dma_len;
    assign dma_enable = res_reg.dma_enable;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the transmit ring DMA chunker. A queue of byte
// writes and DMA completions feeds a valid/ready driver; a local ring model
// predicts each result, and the monitor compares every output transfer field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RING_SIZE = 256;
    localparam int OUT_W     = tdc_pkg::OUT_W;

    typedef struct packed {
        logic       req;
        logic [7:0] data;
        logic       last;
    } tx_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       req_type = tdc_pkg::REQ_WRITE;
    logic [7:0] data_byte = 8'h00;
    logic       last_in_write = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       accepted;
    logic       dma_start;
    logic [7:0] dma_addr;
    logic [7:0] dma_len;
    logic       dma_enable;

    tx_item_t          tx_items[$];
    tdc_pkg::result_t  pending_results[$];
    tx_item_t          cur_item = '0;
    bit                offering = 1'b0;
    logic              in_fire = 1'b0;
    int                snd_idle_pct = 0;
    int                rcv_idle_pct = 0;
    int                stall_left = 0;
    int                err_count = 0;

    // ring model state
    int ring_head = 0;
    int ring_tail = 0;
    int chunk_len = 0;
    bit dma_busy = 1'b0;
    bit dma_on = 1'b0;
    bit call_stored = 1'b0;

    tx_ring_dma_chunker_core #(
        .RING_SIZE(RING_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .data_byte(data_byte),
        .last_in_write(last_in_write),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .accepted(accepted),
        .dma_start(dma_start),
        .dma_addr(dma_addr),
        .dma_len(dma_len),
        .dma_enable(dma_enable)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // issue the longest non-wrapping run from the tail
    function automatic void issue_chunk(inout tdc_pkg::result_t r);
        int run;
        if (dma_busy || ring_head == ring_tail)
            return;
        run = (ring_head >= ring_tail) ? (ring_head - ring_tail) : (RING_SIZE - ring_tail);
        if (run == 0)
            return;
        chunk_len = run;
        dma_busy = 1'b1;
        dma_on = 1'b1;
        r.dma_start = 1'b1;
        r.dma_addr = OUT_W'(ring_tail);
        r.dma_len = OUT_W'(run);
    endfunction

    function automatic tdc_pkg::result_t chunker_step(input tx_item_t it);
        tdc_pkg::result_t r;
        int nxt;
        r = '0;
        if (it.req == tdc_pkg::REQ_WRITE)
        begin
            nxt = (ring_head + 1) % RING_SIZE;
            if (nxt != ring_tail)
            begin
                ring_head = nxt;
                r.accepted = 1'b1;
                call_stored = 1'b1;
            end
            if (it.last)
            begin
                if (call_stored)
                    issue_chunk(r);
                call_stored = 1'b0;
            end
        end
        else
        begin
            ring_tail = (ring_tail + chunk_len) % RING_SIZE;
            chunk_len = 0;
            dma_busy = 1'b0;
            issue_chunk(r);
            if (!dma_busy && ring_head == ring_tail)
                dma_on = 1'b0;
        end
        r.dma_enable = dma_on;
        return r;
    endfunction

    task automatic queue_item(input logic req, input logic [7:0] data, input logic last);
        tx_item_t it;
        it.req = req;
        it.data = data;
        it.last = last;
        tx_items.push_back(it);
    endtask

    task automatic queue_write_call(input int len, input bit with_last);
        for (int i = 0; i < len; i++)
            queue_item(tdc_pkg::REQ_WRITE, 8'($urandom_range(255)),
                       with_last && (i == len - 1));
    endtask

    task automatic queue_done();
        queue_item(tdc_pkg::REQ_DONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // mostly complete write calls and completions, some noise
    task automatic queue_random(input int n);
        int start;
        int pick;
        int len;
        start = tx_items.size();
        while (tx_items.size() - start < n)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                len = $urandom_range(9);
                if (len < 7)
                    len = $urandom_range(6, 1);
                else if (len < 9)
                    len = $urandom_range(60, 10);
                else
                    len = $urandom_range(300, 200);
                queue_write_call(len, $urandom_range(19) != 0);
            end
            else if (pick < 90)
                queue_done();
            else
                queue_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                           1'($urandom_range(1)));
        end
    endtask

    task automatic wait_drained();
        while (tx_items.size() != 0 || offering || pending_results.size() != 0)
            @(posedge clk);
    endtask

    // driver: predicts on each accepted transfer, then offers the next item
    always @(negedge clk)
    begin
        if (in_fire)
        begin
            pending_results.push_back(chunker_step(cur_item));
            offering = 1'b0;
        end
        if (!offering && rst_n && tx_items.size() != 0 && $urandom_range(99) >= snd_idle_pct)
        begin
            cur_item = tx_items.pop_front();
            offering = 1'b1;
        end
        in_valid <= offering;
        req_type <= cur_item.req;
        data_byte <= cur_item.data;
        last_in_write <= cur_item.last;
    end

    always @(negedge clk)
    begin
        out_ready <= (stall_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
    end

    // monitor
    always @(posedge clk)
    begin
        tdc_pkg::result_t want;
        in_fire <= rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                flag_error("result transfer with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                if (accepted !== want.accepted)
                    flag_error($sformatf("accepted got %b exp %b", accepted, want.accepted));
                if (dma_start !== want.dma_start)
                    flag_error($sformatf("dma_start got %b exp %b", dma_start, want.dma_start));
                if (dma_addr !== want.dma_addr)
                    flag_error($sformatf("dma_addr got %h exp %h", dma_addr, want.dma_addr));
                if (dma_len !== want.dma_len)
                    flag_error($sformatf("dma_len got %h exp %h", dma_len, want.dma_len));
                if (dma_enable !== want.dma_enable)
                    flag_error($sformatf("dma_enable got %b exp %b", dma_enable,
                                         want.dma_enable));
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        snd_idle_pct = 10;
        rcv_idle_pct = 67;
        // directed: extremes, overlap with busy, idle done, enable drop
        queue_item(tdc_pkg::REQ_WRITE, 8'h00, 1'b0);
        queue_item(tdc_pkg::REQ_WRITE, 8'hFF, 1'b1);
        queue_item(tdc_pkg::REQ_WRITE, 8'hA5, 1'b1);
        queue_item(tdc_pkg::REQ_DONE, 8'hFF, 1'b1);
        queue_item(tdc_pkg::REQ_DONE, 8'h00, 1'b0);
        queue_item(tdc_pkg::REQ_DONE, 8'h55, 1'b1);
        queue_item(tdc_pkg::REQ_WRITE, 8'h5A, 1'b1);
        queue_item(tdc_pkg::REQ_WRITE, 8'h01, 1'b0);
        queue_item(tdc_pkg::REQ_WRITE, 8'h80, 1'b0);
        queue_item(tdc_pkg::REQ_WRITE, 8'h7F, 1'b1);
        queue_item(tdc_pkg::REQ_DONE, 8'h00, 1'b0);
        queue_item(tdc_pkg::REQ_DONE, 8'hFF, 1'b0);
        queue_item(tdc_pkg::REQ_DONE, 8'h00, 1'b0);
        // fill to full, then a call that stores nothing while busy
        queue_write_call(260, 1'b1);
        queue_write_call(3, 1'b1);
        queue_done();
        queue_write_call(4, 1'b1);
        queue_done();
        queue_done();
        queue_done();
        queue_random(250);
        wait_drained();

        // receiver holds off while the sender keeps offering
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        @(negedge clk);
        stall_left = 60;
        queue_random(30);
        wait_drained();

        snd_idle_pct = 67;
        rcv_idle_pct = 10;
        queue_random(330);
        wait_drained();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        queue_random(330);
        wait_drained();

        repeat (5) @(posedge clk);
        if (err_count == 0)
            $display("[tx_ring_dma_chunker_core] OK");
        else
            $display("[tx_ring_dma_chunker_core] ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("[tx_ring_dma_chunker_core] ERROR");
        $finish;
    end

endmodule
